// File: hdl/lfc_pkg.sv
`default_nettype none

package lfc_pkg;

    // field widths
    localparam int TARGET_W = 8;
    localparam int SIGNAL_W = 10;
    localparam int TIME_W   = 32;
    localparam int DUTY_W   = 8;
    localparam int MS_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // shared divider: dividend < 256 * divisor, so the quotient fits in 8 bits
    localparam int QUO_W      = 8;
    localparam int DIVISOR_W  = 16;
    localparam int DIVIDEND_W = DIVISOR_W + QUO_W;
    localparam int CNT_W      = $clog2(QUO_W);

    localparam logic [DUTY_W-1:0]    FULL_SCALE     = 8'd255;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_THR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT  = 3'd4;

    typedef enum logic [1:0] {
        PH_FADE_IN  = 2'd0,
        PH_ACTIVE   = 2'd1,
        PH_FADE_OUT = 2'd2,
        PH_OFF      = 2'd3
    } phase_t;

endpackage

`default_nettype wire

// File: hdl/lfc_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Caller guarantees dividend < 2^QUO_W * divisor.
module lfc_div
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [lfc_pkg::DIVIDEND_W-1:0]   dividend,
    input  wire logic [lfc_pkg::DIVISOR_W-1:0]    divisor,
    output logic                                  done,
    output logic [lfc_pkg::QUO_W-1:0]             quotient
);

    logic [lfc_pkg::DIVISOR_W-1:0] rem_reg, rem_next;
    logic [lfc_pkg::DIVISOR_W-1:0] dvs_reg;
    logic [lfc_pkg::QUO_W-1:0]     low_reg, low_next;
    logic [lfc_pkg::CNT_W-1:0]     cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [lfc_pkg::DIVISOR_W:0]   shifted;
    logic [lfc_pkg::DIVISOR_W:0]   diff;
    logic                          ge;

    always_comb
    begin
        shifted  = {rem_reg, low_reg[lfc_pkg::QUO_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = ge ? diff[lfc_pkg::DIVISOR_W-1:0] : shifted[lfc_pkg::DIVISOR_W-1:0];
        low_next = {low_reg[lfc_pkg::QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= lfc_pkg::CNT_W'(lfc_pkg::QUO_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - lfc_pkg::CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[lfc_pkg::DIVIDEND_W-1:lfc_pkg::QUO_W];
            low_reg <= dividend[lfc_pkg::QUO_W-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

`default_nettype wire

// File: hdl/led_fade_controller.sv
`default_nettype none

// LED fade controller. Each input word carries a target brightness, a filtered
// signal level and the current millisecond time; each one yields exactly one
// output word with the PWM duty and the phase (0 fading in, 1 active,
// 2 fading out, 3 off). A signal above on_threshold while fading out or off
// restarts a linear fade-in from 0 to the target; a signal held below
// off_threshold for off_debounce_ms while fading in or active starts a
// fade-out from the present duty. A debounce timer that would start at time 0
// reads as not running. Configuration is written through the cfg port
// (index 0..4: off threshold, on threshold, off debounce time, fade-in time,
// fade-out time); other indexes are ignored and cfg_ready is always high.
// Words are handled one at a time: a new word is taken only in the idle state.
// A word in an active or off phase passes the debounce, phase and ramp steps
// and goes straight to output; a fading word whose ramp has run out adds a
// multiply, then a shift-add divide by 255; a word mid-ramp first takes one
// pass through the shared 8-step serial divider for progress =
// elapsed*255/ramp length, then the multiply and divide. The output register
// lets the next word be taken while a result still waits for out_ready; the
// word after that stalls in its last step until the output register frees up.
module led_fade_controller
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lfc_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [lfc_pkg::TARGET_W-1:0]      target_level,
    input  wire logic [lfc_pkg::SIGNAL_W-1:0]      signal_level,
    input  wire logic [lfc_pkg::TIME_W-1:0]        time_ms,

    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [lfc_pkg::DUTY_W-1:0]             duty,
    output logic [1:0]                             phase
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b0_0000_0001,
        ST_EVAL  = 9'b0_0000_0010,  // debounce timer, on/off decision
        ST_PHASE = 9'b0_0000_0100,  // phase transitions
        ST_RAMP  = 9'b0_0000_1000,  // elapsed time vs ramp length
        ST_RDIV  = 9'b0_0001_0000,  // start progress division
        ST_DIV1  = 9'b0_0010_0000,
        ST_MUL   = 9'b0_0100_0000,  // value * progress
        ST_SCALE = 9'b0_1000_0000,  // /255 by shift-add
        ST_DONE  = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [lfc_pkg::SIGNAL_W-1:0] off_thr_reg, on_thr_reg;
    logic [lfc_pkg::MS_W-1:0]     debounce_reg, fade_in_reg, fade_out_reg;

    // block state
    lfc_pkg::phase_t              phase_reg;
    logic [lfc_pkg::DUTY_W-1:0]   last_duty_reg;
    logic [lfc_pkg::DUTY_W-1:0]   start_duty_reg;
    logic [lfc_pkg::TIME_W-1:0]   start_time_reg;
    logic [lfc_pkg::TIME_W-1:0]   below_since_reg;

    // captured word and intermediates
    logic [lfc_pkg::TARGET_W-1:0] tgt_reg;
    logic [lfc_pkg::SIGNAL_W-1:0] sig_reg;
    logic [lfc_pkg::TIME_W-1:0]   now_reg;
    logic                         sig_on_reg, sig_off_reg;
    logic [lfc_pkg::MS_W-1:0]     elapsed_reg;
    logic [lfc_pkg::QUO_W-1:0]    prog_reg;
    logic [2*lfc_pkg::DUTY_W-1:0] prod_reg;
    logic [lfc_pkg::DUTY_W-1:0]   scaled_reg;

    // output register
    logic                         out_valid_reg;
    logic [lfc_pkg::DUTY_W-1:0]   duty_reg;
    lfc_pkg::phase_t              phase_out_reg;

    // combinational helpers
    logic                         below;
    logic [lfc_pkg::TIME_W-1:0]   bs_new;
    logic [lfc_pkg::TIME_W-1:0]   bs_elapsed;
    logic                         is_fade;
    logic [lfc_pkg::MS_W-1:0]     ramp_len;
    logic [lfc_pkg::TIME_W-1:0]   elapsed;
    logic [lfc_pkg::DUTY_W-1:0]   scale_val;
    logic [2*lfc_pkg::DUTY_W-1:0] scale_sum;
    logic [lfc_pkg::DUTY_W-1:0]   duty_calc;
    lfc_pkg::phase_t              phase_calc;
    logic                         out_free;

    // divider hookup
    logic                              div_start;
    logic [lfc_pkg::DIVIDEND_W-1:0]    div_dividend;
    logic [lfc_pkg::DIVISOR_W-1:0]     div_divisor;
    logic                              div_done;
    logic [lfc_pkg::QUO_W-1:0]         div_quo;

    lfc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        // debounce timer; a start at time 0 leaves it "not running"
        below      = (sig_reg < off_thr_reg);
        if (!below)
            bs_new = '0;
        else if (below_since_reg == '0)
            bs_new = now_reg;
        else
            bs_new = below_since_reg;
        bs_elapsed = now_reg - bs_new;

        is_fade  = (phase_reg == lfc_pkg::PH_FADE_IN) || (phase_reg == lfc_pkg::PH_FADE_OUT);
        ramp_len = (phase_reg == lfc_pkg::PH_FADE_IN) ? fade_in_reg : fade_out_reg;
        elapsed  = now_reg - start_time_reg;

        // fade-in scales (target - start) mod 256, fade-out scales start
        scale_val = (phase_reg == lfc_pkg::PH_FADE_IN) ? (tgt_reg - start_duty_reg)
                                                       : start_duty_reg;

        // x/255 = (x + (x >> 8) + 1) >> 8, exact for x <= 255*255
        scale_sum = prod_reg + {{lfc_pkg::DUTY_W{1'b0}}, prod_reg[2*lfc_pkg::DUTY_W-1:lfc_pkg::DUTY_W]}
                  + {{(2*lfc_pkg::DUTY_W-1){1'b0}}, 1'b1};

        div_start    = (state_reg == ST_RDIV);
        // elapsed * 255 = (elapsed << 8) - elapsed
        div_dividend = {elapsed_reg, {lfc_pkg::QUO_W{1'b0}}}
                     - {{lfc_pkg::QUO_W{1'b0}}, elapsed_reg};
        div_divisor  = ramp_len;

        duty_calc  = '0;
        phase_calc = phase_reg;
        case (phase_reg)
            lfc_pkg::PH_FADE_IN:
            begin
                duty_calc = start_duty_reg + scaled_reg;
                if (prog_reg == lfc_pkg::FULL_SCALE)
                    phase_calc = lfc_pkg::PH_ACTIVE;
            end
            lfc_pkg::PH_ACTIVE:
            begin
                duty_calc = tgt_reg;
            end
            lfc_pkg::PH_FADE_OUT:
            begin
                duty_calc = start_duty_reg - scaled_reg;
                if (prog_reg == lfc_pkg::FULL_SCALE)
                    phase_calc = lfc_pkg::PH_OFF;
            end
            default:
            begin
                duty_calc = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_PHASE;
            ST_PHASE: state_next = ST_RAMP;
            ST_RAMP:
            begin
                if (!is_fade)
                    state_next = ST_DONE;
                else if (elapsed >= {{(lfc_pkg::TIME_W-lfc_pkg::MS_W){1'b0}}, ramp_len})
                    state_next = ST_MUL;
                else
                    state_next = ST_RDIV;
            end
            ST_RDIV:  state_next = ST_DIV1;
            ST_DIV1:  if (div_done) state_next = ST_MUL;
            ST_MUL:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            off_thr_reg     <= 10'd100;
            on_thr_reg      <= 10'd200;
            debounce_reg    <= 16'd500;
            fade_in_reg     <= 16'd1000;
            fade_out_reg    <= 16'd1000;
            phase_reg       <= lfc_pkg::PH_FADE_IN;
            last_duty_reg   <= '0;
            start_duty_reg  <= '0;
            start_time_reg  <= '0;
            below_since_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lfc_pkg::CFG_OFF_THR:  off_thr_reg  <= cfg_data[lfc_pkg::SIGNAL_W-1:0];
                    lfc_pkg::CFG_ON_THR:   on_thr_reg   <= cfg_data[lfc_pkg::SIGNAL_W-1:0];
                    lfc_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_data;
                    lfc_pkg::CFG_FADE_IN:  fade_in_reg  <= cfg_data;
                    lfc_pkg::CFG_FADE_OUT: fade_out_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == ST_EVAL)
                below_since_reg <= bs_new;

            if (state_reg == ST_PHASE)
            begin
                if (sig_on_reg && ((phase_reg == lfc_pkg::PH_FADE_OUT) ||
                                   (phase_reg == lfc_pkg::PH_OFF)))
                begin
                    phase_reg      <= lfc_pkg::PH_FADE_IN;
                    start_duty_reg <= '0;
                    start_time_reg <= now_reg;
                end
                else if (sig_off_reg && ((phase_reg == lfc_pkg::PH_ACTIVE) ||
                                         (phase_reg == lfc_pkg::PH_FADE_IN)))
                begin
                    phase_reg      <= lfc_pkg::PH_FADE_OUT;
                    start_duty_reg <= last_duty_reg;
                    start_time_reg <= now_reg;
                end
            end

            if ((state_reg == ST_DONE) && out_free)
            begin
                phase_reg     <= phase_calc;
                last_duty_reg <= duty_calc;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tgt_reg <= target_level;
            sig_reg <= signal_level;
            now_reg <= time_ms;
        end

        if (state_reg == ST_EVAL)
        begin
            sig_on_reg  <= (sig_reg > on_thr_reg);
            sig_off_reg <= below && (bs_new != '0) &&
                           (bs_elapsed >= {{(lfc_pkg::TIME_W-lfc_pkg::MS_W){1'b0}}, debounce_reg});
        end

        if (state_reg == ST_RAMP)
        begin
            elapsed_reg <= elapsed[lfc_pkg::MS_W-1:0];
            prog_reg    <= lfc_pkg::FULL_SCALE;
        end

        if ((state_reg == ST_DIV1) && div_done)
            prog_reg <= div_quo;

        if (state_reg == ST_MUL)
            prod_reg <= {{lfc_pkg::DUTY_W{1'b0}}, scale_val} * {{lfc_pkg::QUO_W{1'b0}}, prog_reg};

        if (state_reg == ST_SCALE)
            scaled_reg <= scale_sum[2*lfc_pkg::DUTY_W-1:lfc_pkg::DUTY_W];

        if ((state_reg == ST_DONE) && out_free)
        begin
            duty_reg      <= duty_calc;
            phase_out_reg <= phase_calc;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty      = duty_reg;
    assign phase     = phase_out_reg;

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    // Settle time after the last result, enough for a mid-ramp word to finish.
    localparam int SETTLE_CYCLES = 40;
    localparam int WORDS_PER_SEC = 215;
    localparam int NUM_SECTIONS  = 6;

    // One expected output word.
    typedef struct packed {
        logic [lfc_pkg::DUTY_W-1:0] duty;
        lfc_pkg::phase_t            ph;
    } fade_word_t;

    // Scoreboard: carries its own copy of the fade state machine and the
    // register file, predicts one output word per accepted input word and
    // checks the outputs in order.
    class fade_scoreboard_t;
        logic [lfc_pkg::SIGNAL_W-1:0] off_thr;
        logic [lfc_pkg::SIGNAL_W-1:0] on_thr;
        logic [lfc_pkg::MS_W-1:0]     debounce_len;
        logic [lfc_pkg::MS_W-1:0]     fade_in_len;
        logic [lfc_pkg::MS_W-1:0]     fade_out_len;
        lfc_pkg::phase_t              cur_phase;
        logic [lfc_pkg::DUTY_W-1:0]   prev_duty;
        logic [lfc_pkg::DUTY_W-1:0]   ramp_base;
        logic [lfc_pkg::TIME_W-1:0]   ramp_t0;
        logic [lfc_pkg::TIME_W-1:0]   below_t0;
        fade_word_t                   due_q[$];
        int                           errors;

        function new();
            off_thr      = 10'd100;
            on_thr       = 10'd200;
            debounce_len = 16'd500;
            fade_in_len  = 16'd1000;
            fade_out_len = 16'd1000;
            cur_phase    = lfc_pkg::PH_FADE_IN;
            prev_duty    = '0;
            ramp_base    = '0;
            ramp_t0      = '0;
            below_t0     = '0;
            errors       = 0;
        endfunction

        // Extra data bits beyond a field are dropped; unknown indexes are ignored.
        function void write_reg(logic [lfc_pkg::CFG_IDX_W-1:0] idx,
                                logic [lfc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lfc_pkg::CFG_OFF_THR:  off_thr      = data[lfc_pkg::SIGNAL_W-1:0];
                lfc_pkg::CFG_ON_THR:   on_thr       = data[lfc_pkg::SIGNAL_W-1:0];
                lfc_pkg::CFG_DEBOUNCE: debounce_len = data[lfc_pkg::MS_W-1:0];
                lfc_pkg::CFG_FADE_IN:  fade_in_len  = data[lfc_pkg::MS_W-1:0];
                lfc_pkg::CFG_FADE_OUT: fade_out_len = data[lfc_pkg::MS_W-1:0];
                default: ;
            endcase
        endfunction

        // elapsed*255/len, saturating at 255; a zero length saturates at once.
        static function logic [31:0] ramp_pos(logic [lfc_pkg::TIME_W-1:0] elapsed,
                                              logic [lfc_pkg::MS_W-1:0] len);
            if (elapsed < {16'd0, len})
                return (elapsed * 32'd255) / {16'd0, len};
            return 32'd255;
        endfunction

        function void note_input(logic [lfc_pkg::TARGET_W-1:0] tgt,
                                 logic [lfc_pkg::SIGNAL_W-1:0] sig,
                                 logic [lfc_pkg::TIME_W-1:0] now);
            bit                         below;
            bit                         sig_on;
            bit                         sig_off;
            logic [lfc_pkg::TIME_W-1:0] since;
            logic [31:0]                p;
            logic [31:0]                scaled;
            logic [lfc_pkg::DUTY_W-1:0] diff;
            logic [lfc_pkg::DUTY_W-1:0] d;
            fade_word_t                 w;

            below  = sig < off_thr;
            sig_on = sig > on_thr;
            // a timer that would start at time zero reads as not running
            if (below)
            begin
                if (below_t0 == '0)
                    below_t0 = now;
            end
            else
            begin
                below_t0 = '0;
            end
            since   = now - below_t0;
            sig_off = below && (below_t0 != '0) && (since >= {16'd0, debounce_len});

            if (sig_on && (cur_phase == lfc_pkg::PH_FADE_OUT || cur_phase == lfc_pkg::PH_OFF))
            begin
                cur_phase = lfc_pkg::PH_FADE_IN;
                ramp_base = '0;
                ramp_t0   = now;
            end
            else if (sig_off && (cur_phase == lfc_pkg::PH_ACTIVE ||
                                 cur_phase == lfc_pkg::PH_FADE_IN))
            begin
                cur_phase = lfc_pkg::PH_FADE_OUT;
                ramp_base = prev_duty;
                ramp_t0   = now;
            end

            case (cur_phase)
                lfc_pkg::PH_FADE_IN:
                begin
                    p      = ramp_pos(now - ramp_t0, fade_in_len);
                    diff   = tgt - ramp_base;
                    scaled = (diff * p) / 32'd255;
                    d      = ramp_base + scaled[lfc_pkg::DUTY_W-1:0];
                    if (p >= 32'd255)
                        cur_phase = lfc_pkg::PH_ACTIVE;
                end
                lfc_pkg::PH_ACTIVE: d = tgt;
                lfc_pkg::PH_FADE_OUT:
                begin
                    p      = ramp_pos(now - ramp_t0, fade_out_len);
                    scaled = (ramp_base * p) / 32'd255;
                    d      = ramp_base - scaled[lfc_pkg::DUTY_W-1:0];
                    if (p >= 32'd255)
                        cur_phase = lfc_pkg::PH_OFF;
                end
                default: d = '0;
            endcase
            prev_duty = d;
            w.duty    = d;
            w.ph      = cur_phase;
            due_q.push_back(w);
        endfunction

        function void check_result(logic [lfc_pkg::DUTY_W-1:0] d, logic [1:0] ph);
            fade_word_t w;
            if (due_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output word: expected none, got duty %0d phase %0d",
                         $time, d, ph);
                return;
            end
            w = due_q.pop_front();
            if (d !== w.duty)
            begin
                errors++;
                $display("%0t: duty mismatch: expected %0d, got %0d", $time, w.duty, d);
            end
            if (ph !== w.ph)
            begin
                errors++;
                $display("%0t: phase mismatch: expected %0d, got %0d", $time, w.ph, ph);
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // Clock, reset and DUT signals. Everything is known from time zero.
    // ---------------------------------------------------------------------
    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic [lfc_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [lfc_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                           in_valid     = 1'b0;
    logic                           in_ready;
    logic [lfc_pkg::TARGET_W-1:0]   target_level = '0;
    logic [lfc_pkg::SIGNAL_W-1:0]   signal_level = '0;
    logic [lfc_pkg::TIME_W-1:0]     time_ms      = '0;
    logic                           out_valid;
    logic                           out_ready    = 1'b0;
    logic [lfc_pkg::DUTY_W-1:0]     duty;
    logic [1:0]                     phase;

    fade_scoreboard_t sb = new();

    // Stimulus knobs
    int                         send_idle_pct = 0;   // sender gap chance per cycle, percent
    int                         recv_idle_pct = 0;   // receiver stall chance per cycle, percent
    int                         hold_req      = 0;   // long receiver hold-off, in cycles
    bit                         hold_done     = 1'b0;
    int                         hold_left     = 0;
    int                         words_sent    = 0;
    logic [lfc_pkg::TIME_W-1:0] cur_time      = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    led_fade_controller u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .target_level (target_level),
        .signal_level (signal_level),
        .time_ms      (time_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .duty         (duty),
        .phase        (phase)
    );

    // ---------------------------------------------------------------------
    // Output side: check every accepted word, then pick next cycle's ready.
    // A long hold-off, when requested, is counted down here so the sender
    // keeps offering words and the block backs up into in_ready.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(duty, phase);
            if ((hold_req > 0) && !hold_done)
            begin
                hold_left = hold_req;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Drivers. Each is entered right after a rising edge; valid stays high
    // from one word to the next unless the sender decides to idle.
    // ---------------------------------------------------------------------
    task automatic send_word(input logic [lfc_pkg::TARGET_W-1:0] tgt,
                             input logic [lfc_pkg::SIGNAL_W-1:0] sig,
                             input logic [lfc_pkg::TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        target_level <= tgt;
        signal_level <= sig;
        time_ms      <= now;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(tgt, sig, now);
        words_sent++;
    endtask

    task automatic cfg_write(input logic [lfc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lfc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering words and wait until every predicted word has come out,
    // then let the datapath settle so a register write lands on an idle block.
    task automatic drain_words();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_all(input logic [lfc_pkg::CFG_DATA_W-1:0] off_v,
                           input logic [lfc_pkg::CFG_DATA_W-1:0] on_v,
                           input logic [lfc_pkg::CFG_DATA_W-1:0] deb_v,
                           input logic [lfc_pkg::CFG_DATA_W-1:0] fin_v,
                           input logic [lfc_pkg::CFG_DATA_W-1:0] fout_v);
        cfg_write(lfc_pkg::CFG_OFF_THR, off_v);
        cfg_write(lfc_pkg::CFG_ON_THR, on_v);
        cfg_write(lfc_pkg::CFG_DEBOUNCE, deb_v);
        cfg_write(lfc_pkg::CFG_FADE_IN, fin_v);
        cfg_write(lfc_pkg::CFG_FADE_OUT, fout_v);
    endtask

    // Random register value in [lo, hi].
    function automatic logic [lfc_pkg::CFG_DATA_W-1:0] cfg_rand(input int unsigned hi,
                                                                input int unsigned lo);
        return lfc_pkg::CFG_DATA_W'($urandom_range(hi, lo));
    endfunction

    // Signal levels relative to the current thresholds.
    function automatic logic [lfc_pkg::SIGNAL_W-1:0] on_level();
        if (sb.on_thr == 10'd1023)
            return 10'd1023;
        return lfc_pkg::SIGNAL_W'($urandom_range(1023, sb.on_thr + 1));
    endfunction

    function automatic logic [lfc_pkg::SIGNAL_W-1:0] below_level();
        if (sb.off_thr == 10'd0)
            return 10'd0;
        return lfc_pkg::SIGNAL_W'($urandom_range(sb.off_thr - 1, 0));
    endfunction

    function automatic logic [lfc_pkg::SIGNAL_W-1:0] band_level();
        if (sb.off_thr > sb.on_thr)
            return sb.off_thr;
        return lfc_pkg::SIGNAL_W'($urandom_range(sb.on_thr, sb.off_thr));
    endfunction

    task automatic next_word(input logic [lfc_pkg::TARGET_W-1:0] tgt,
                             input logic [lfc_pkg::SIGNAL_W-1:0] sig,
                             input int unsigned span);
        logic [lfc_pkg::TARGET_W-1:0] t;
        cur_time = cur_time + $urandom_range(span, 0);
        t = ($urandom_range(4) == 0) ? lfc_pkg::TARGET_W'($urandom) : tgt;
        send_word(t, sig, cur_time);
    endtask

    // One episode: mostly a clean on / off cycle with random content, so the
    // fade-in, active, debounce and fade-out paths are all walked; the rest
    // is noise with arbitrary levels and time jumps.
    task automatic run_episode();
        logic [lfc_pkg::TARGET_W-1:0] tgt;
        logic [lfc_pkg::MS_W-1:0]     longest;
        int unsigned                  span;
        tgt     = lfc_pkg::TARGET_W'($urandom);
        longest = sb.fade_in_len;
        if (sb.fade_out_len > longest)
            longest = sb.fade_out_len;
        if (sb.debounce_len > longest)
            longest = sb.debounce_len;
        span = longest / 5 + 1;
        if ($urandom_range(99) < 10)
        begin
            repeat ($urandom_range(3, 1))
            begin
                if ($urandom_range(1))
                    cur_time = $urandom;
                send_word(lfc_pkg::TARGET_W'($urandom), lfc_pkg::SIGNAL_W'($urandom),
                          $urandom_range(1) ? cur_time : $urandom);
            end
        end
        else
        begin
            repeat ($urandom_range(8, 1)) next_word(tgt, on_level(), span);
            repeat ($urandom_range(3, 0)) next_word(tgt, band_level(), span);
            // drop-out; an odd blip above the off threshold restarts the debounce
            repeat ($urandom_range(10, 2))
                next_word(tgt, ($urandom_range(9) == 0) ? band_level() : below_level(), span);
        end
    endtask

    // Hand-picked words: field extremes, debounce starting at time zero,
    // clock wrap, zero-length ramps, inverted hysteresis, ignored and
    // oversized register writes.
    task automatic directed_words();
        // first fade-in after reset is timed from zero
        send_word(8'd255, 10'd150, 32'd0);
        send_word(8'd255, 10'd150, 32'd500);
        send_word(8'd255, 10'd150, 32'd1000);
        // below at time zero: timer stays idle, restarts on the next word
        send_word(8'd255, 10'd0, 32'd0);
        send_word(8'd255, 10'd0, 32'd600);
        send_word(8'd255, 10'd0, 32'd1100);
        send_word(8'd255, 10'd0, 32'd1600);
        send_word(8'd0, 10'd1023, 32'd2100);
        send_word(8'd0, 10'd1023, 32'd3200);
        send_word(8'd128, 10'd1023, 32'hFFFF_FFF0);
        // debounce across the clock wrap
        send_word(8'd128, 10'd0, 32'hFFFF_FF00);
        send_word(8'd128, 10'd0, 32'h0000_0200);
        send_word(8'd128, 10'd0, 32'h0000_0400);
        send_word(8'd128, 10'd512, 32'hFFFF_FFFF);
        send_word(8'd255, 10'd1023, 32'hFFFF_FFFF);
        drain_words();
        // oversized thresholds, zero debounce and zero-length ramps
        cfg_all(16'hFFFF, 16'hFC00, 16'd0, 16'd0, 16'd0);
        for (int i = lfc_pkg::CFG_FADE_OUT + 1; i < (1 << lfc_pkg::CFG_IDX_W); i++)
            cfg_write(lfc_pkg::CFG_IDX_W'(i), cfg_rand(65535, 0));
        send_word(8'd200, 10'd512, 32'd10);
        send_word(8'd200, 10'd512, 32'd20);
        send_word(8'd77, 10'd0, 32'd30);
        send_word(8'd255, 10'd1023, 32'd40);
        send_word(8'd1, 10'd1022, 32'd50);
        drain_words();
    endtask

    task automatic load_section_cfg(input int sec);
        logic [lfc_pkg::CFG_DATA_W-1:0] lo;
        case (sec)
            0: cfg_all(16'd300, 16'd600, cfg_rand(200, 0), cfg_rand(300, 1),
                       cfg_rand(300, 1));
            1: cfg_all(16'd1023, 16'd0, 16'd0, 16'd65535, 16'd1);
            2: cfg_all(cfg_rand(65535, 0), cfg_rand(65535, 0), cfg_rand(2000, 0),
                       cfg_rand(5000, 1), cfg_rand(5000, 1));
            3: cfg_all(16'd1, 16'd1022, 16'd65535, 16'd1, 16'd65535);
            4:
            begin
                lo = cfg_rand(511, 0);
                cfg_all(lo, cfg_rand(1023, lo), cfg_rand(100, 0),
                        cfg_rand(100, 1), cfg_rand(100, 1));
            end
            default: cfg_all(16'd100, 16'd200, 16'd500, 16'd1000, 16'd1000);
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        int  goal;
        int  waited;
        bit  held;
        bit  paused;
        held   = 1'b0;
        paused = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();

        for (int sec = 0; sec < NUM_SECTIONS; sec++)
        begin
            drain_words();
            load_section_cfg(sec);
            // idling: receiver-heavy gaps, then sender-heavy, then none
            case (sec / 2)
                0:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 49;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_idle_pct = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (sec == 2)
                cur_time = 32'hFFFF_0000 + $urandom_range(32'h0000_F000, 0);
            goal = words_sent + WORDS_PER_SEC;
            while (words_sent < goal)
            begin
                run_episode();
                // receiver holds off while the sender keeps pushing
                if (sec == 4 && !held && words_sent > goal - 150)
                begin
                    hold_req = 400;
                    held     = 1'b1;
                end
                // sender pauses until every expected word is back
                if (sec == 1 && !paused && words_sent > goal - 100)
                begin
                    drain_words();
                    paused = 1'b1;
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (sb.pending() > 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending() > 0)
        begin
            $display("%0t: %0d expected output words never arrived", $time, sb.pending());
            sb.errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("** led_fade_controller: PASSED **");
        else
            $display("** led_fade_controller: FAILED **");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("%0t: timeout", $time);
        $display("** led_fade_controller: FAILED **");
        $finish;
    end

endmodule
